### rtl/assert_macros.svh
// Assertion macros for the RTL files.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop holds at every clock edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond never holds outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

### rtl/itoa_pkg.sv
// Package for the integer to ASCII formatter: widths, command codes,
// characters, state and control types, digit-to-character function.
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int CMD_W       = 3;
    localparam int CHAR_W      = 8;

    localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W      = NUM_DIGITS * 4;
    localparam int HEX_SHIFT  = (NUM_DIGITS - HEX_DIGITS) * 4;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HEXL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HEXU = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PTR  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREFIX,
        ST_DIGITS
    } state_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_PTR
    } pfx_t;

    typedef struct packed {
        logic load;
        logic hex;
        logic negate;
        logic step;
        logic shift;
    } dp_ctl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        if (d < 4'd10)
        begin
            digit_char = CH_ZERO + {4'd0, d};
        end
        else
        begin
            base = upper ? CH_UA : CH_LA;
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/itoa_if.sv
// Valid/ready channel interfaces for the formatter's input and output words.
// Depends on itoa_pkg.
`default_nettype none

interface itoa_in_if import itoa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IN_W-1:0]  value;
    logic [CMD_W-1:0] command;

    modport source (output valid, value, command, input ready);
    modport sink   (input valid, value, command, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, character, last, input ready);
    modport sink   (input valid, character, last, output ready);
endinterface

`default_nettype wire

### rtl/integer_to_ascii_formatter_core.sv
// Integer to ASCII formatter, top level.
// Depends on itoa_pkg, itoa_if, itoa_dabble, itoa_ctrl, assert_macros.svh.
//
// in_word carries a 32-bit value and a format command (signed decimal,
// unsigned decimal, lower hex, upper hex, pointer). out_word returns one
// ASCII character per word, most significant first, last set on the final one.
// Unused commands are taken and dropped without output.
// Decimal: the word is accepted, then VALUE_WIDTH bit-serial shift-and-add-3
// steps run, then each prefix character and each digit position (NUM_DIGITS)
// is emitted in turn, with leading zero positions skipped. Hex skips the
// conversion and emits HEX_DIGITS positions; pointer emits a 0x prefix first.
// The next input word is taken once the last character sits in the output
// register, even while that register waits for the receiver.
// A stalled receiver holds the output register and pauses emission; nothing
// is dropped. Reset clears the sequencer and the output valid flag.
`default_nettype none

`include "assert_macros.svh"

module integer_to_ascii_formatter_core import itoa_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    itoa_in_if.sink       in_word,
    itoa_out_if.source    out_word
);

    dp_ctl_t    ctl;
    logic [3:0] top_digit;

    logic       last_shown;
    logic       char_is_digit;
    logic       last_minus;
    logic       last_x;
    logic       bad_cmd_taken;

    itoa_dabble u_dabble (
        .clk       (clk),
        .value     (in_word.value),
        .ctl       (ctl),
        .top_digit (top_digit)
    );

    itoa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_word.valid),
        .in_command (in_word.command),
        .in_sign    (in_word.value[VALUE_WIDTH-1]),
        .in_ready   (in_word.ready),
        .top_digit  (top_digit),
        .ctl        (ctl),
        .out_valid  (out_word.valid),
        .out_ready  (out_word.ready),
        .out_char   (out_word.character),
        .out_last   (out_word.last)
    );

    assign last_shown    = out_word.valid && out_word.last;
    assign char_is_digit = ((out_word.character >= CH_ZERO) && (out_word.character <= 8'h39)) ||
                           ((out_word.character >= CH_LA) && (out_word.character <= 8'h66)) ||
                           ((out_word.character >= CH_UA) && (out_word.character <= 8'h46));
    assign last_minus    = last_shown && (out_word.character == CH_MINUS);
    assign last_x        = last_shown && (out_word.character == CH_X);
    assign bad_cmd_taken = in_word.valid && in_word.ready && (in_word.command > CMD_PTR);

    `ASSERT_PROP(a_last_is_digit, clk, rst_n, last_shown |-> char_is_digit, "last not a digit")
    `ASSERT_NEVER(a_minus_not_last, clk, rst_n, last_minus, "minus sign flagged last")
    `ASSERT_NEVER(a_x_not_last, clk, rst_n, last_x, "pointer prefix flagged last")
    `ASSERT_PROP(a_bad_cmd, clk, rst_n, bad_cmd_taken |=> in_word.ready, "busy after bad command")

endmodule

`default_nettype wire

### rtl/itoa_dabble.sv
// Digit datapath: bit-serial shift-and-add-3 binary to BCD, hex load,
// and digit shift-out from the top nibble. Depends on itoa_pkg.
`default_nettype none

module itoa_dabble import itoa_pkg::*; (
    input  wire logic            clk,
    input  wire logic [IN_W-1:0] value,
    input  wire dp_ctl_t         ctl,
    output logic [3:0]           top_digit
);

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [DIG_W-1:0]       dig_reg;
    logic [VALUE_WIDTH-1:0] load_val;
    logic [VALUE_WIDTH-1:0] load_mag;
    logic [DIG_W-1:0]       adj;

    assign load_val = VALUE_WIDTH'(value);
    assign load_mag = ctl.negate ? (~load_val + 1'b1) : load_val;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                          : dig_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mag_reg <= load_mag;
            dig_reg <= ctl.hex ? (DIG_W'(load_mag) << HEX_SHIFT) : '0;
        end
        else if (ctl.step)
        begin
            mag_reg <= mag_reg << 1;
            dig_reg <= {adj[DIG_W-2:0], mag_reg[VALUE_WIDTH-1]};
        end
        else if (ctl.shift)
        begin
            dig_reg <= dig_reg << 4;
        end
    end

    assign top_digit = dig_reg[DIG_W-1 -: 4];

endmodule

`default_nettype wire

### rtl/itoa_ctrl.sv
// Sequencer: input handshake, conversion count, prefix and digit emission
// with leading-zero skip, output word register. Depends on itoa_pkg.
`default_nettype none

module itoa_ctrl import itoa_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [CMD_W-1:0] in_command,
    input  wire logic             in_sign,
    output logic                  in_ready,
    input  wire logic [3:0]       top_digit,
    output dp_ctl_t               ctl,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [CHAR_W-1:0]     out_char,
    output logic                  out_last
);

    state_t             state_reg, state_next;
    pfx_t               pfx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               upper_reg;
    logic               pre_cnt_reg;
    logic               lead_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic               slot_free;
    logic               cmd_ok;
    logic               cmd_hex;
    logic               start;
    logic               skip;
    logic               wr;
    logic [CHAR_W-1:0]  wr_char;
    logic               wr_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign cmd_ok    = (in_command == CMD_SDEC) || (in_command == CMD_UDEC) ||
                       (in_command == CMD_HEXL) || (in_command == CMD_HEXU) ||
                       (in_command == CMD_PTR);
    assign cmd_hex   = (in_command == CMD_HEXL) || (in_command == CMD_HEXU) ||
                       (in_command == CMD_PTR);
    assign start     = (state_reg == ST_IDLE) && in_valid && cmd_ok;
    assign skip      = lead_reg && (top_digit == 4'd0) && (cnt_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!cmd_hex)
                        state_next = ST_CONV;
                    else if (in_command == CMD_PTR)
                        state_next = ST_PREFIX;
                    else
                        state_next = ST_DIGITS;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == '0)
                    state_next = (pfx_reg == PFX_NONE) ? ST_DIGITS : ST_PREFIX;
            end
            ST_PREFIX:
            begin
                if (slot_free && ((pfx_reg == PFX_MINUS) || pre_cnt_reg))
                    state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                if ((skip || slot_free) && (cnt_reg == '0))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        ctl      = '0;
        wr       = 1'b0;
        wr_char  = CH_ZERO;
        wr_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.load   = start;
                ctl.hex    = cmd_hex;
                ctl.negate = (in_command == CMD_SDEC) && in_sign;
            end
            ST_CONV:
            begin
                ctl.step = 1'b1;
            end
            ST_PREFIX:
            begin
                wr = slot_free;
                if (pfx_reg == PFX_MINUS)
                    wr_char = CH_MINUS;
                else
                    wr_char = pre_cnt_reg ? CH_X : CH_ZERO;
            end
            ST_DIGITS:
            begin
                ctl.shift = skip || slot_free;
                wr        = !skip && slot_free;
                wr_char   = digit_char(top_digit, upper_reg);
                wr_last   = (cnt_reg == '0);
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pfx_reg       <= PFX_NONE;
            cnt_reg       <= '0;
            upper_reg     <= 1'b0;
            pre_cnt_reg   <= 1'b0;
            lead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (start)
            begin
                upper_reg   <= (in_command == CMD_HEXU);
                pre_cnt_reg <= 1'b0;
                lead_reg    <= 1'b1;
                if (in_command == CMD_PTR)
                    pfx_reg <= PFX_PTR;
                else if ((in_command == CMD_SDEC) && in_sign)
                    pfx_reg <= PFX_MINUS;
                else
                    pfx_reg <= PFX_NONE;
                cnt_reg <= cmd_hex ? CNT_W'(HEX_DIGITS - 1) : CNT_W'(VALUE_WIDTH - 1);
            end
            else if (ctl.step)
            begin
                cnt_reg <= (cnt_reg == '0) ? CNT_W'(NUM_DIGITS - 1) : cnt_reg - 1'b1;
            end
            else if (ctl.shift)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (!skip)
                    lead_reg <= 1'b0;
            end

            if ((state_reg == ST_PREFIX) && wr)
                pre_cnt_reg <= 1'b1;

            if (wr)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            char_reg <= wr_char;
            last_reg <= wr_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire
